[rtl/svs_pkg.sv]
// ----------------------------------------------------------------------------
// svs_pkg: shared types and codes for the sorted value store
// Request and response payloads, status and operation codes, and the
// command bundle that the controller broadcasts to the cell row.
// ----------------------------------------------------------------------------
package svs_pkg;

    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic                      operation;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [COUNT_W-1:0]        count;
        logic                      head_valid;
        logic signed [VALUE_W-1:0] head_value;
    } rsp_t;

    // Broadcast to every cell
    typedef struct packed {
        logic cmp_en;   // register compare flags against the key
        logic ins_en;   // apply insert (store not full)
        logic del_en;   // apply delete (match present)
    } cell_cmd_t;

endpackage

[rtl/svs_cell.sv]
// ----------------------------------------------------------------------------
// svs_cell: one slot of the sorted row
// Holds one value, compares it with the broadcast key, and on update keeps
// its value, takes the key, or takes a neighbor's value.
// ----------------------------------------------------------------------------
module svs_cell
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  svs_pkg::cell_cmd_t                 cmd,
    input  logic signed [svs_pkg::VALUE_W-1:0] key,
    input  logic                               occ,
    input  logic                               left_le,
    input  logic signed [svs_pkg::VALUE_W-1:0] left_value,
    input  logic signed [svs_pkg::VALUE_W-1:0] right_value,
    output logic signed [svs_pkg::VALUE_W-1:0] value,
    output logic                               le,
    output logic                               eq
);

    logic signed [svs_pkg::VALUE_W-1:0] value_reg;
    logic signed [svs_pkg::VALUE_W-1:0] value_next;
    logic                               le_reg;
    logic                               lt_reg;
    logic                               eq_reg;

    // flags: occupied and value <= key / < key / == key
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            le_reg <= 1'b0;
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else if (cmd.cmp_en)
        begin
            le_reg <= occ && (value_reg <= key);
            lt_reg <= occ && (value_reg <  key);
            eq_reg <= occ && (value_reg == key);
        end
    end

    always_comb
    begin
        value_next = value_reg;
        if (cmd.ins_en)
        begin
            priority if (le_reg)
                value_next = value_reg;
            else if (left_le)
                value_next = key;
            else
                value_next = left_value;
        end
        else if (cmd.del_en)
        begin
            if (!lt_reg)
                value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign le    = le_reg;
    assign eq    = eq_reg;

endmodule

[rtl/sorted_value_store.sv]
// ----------------------------------------------------------------------------
// sorted_value_store: bounded ascending store of signed 32-bit values
// Insert and delete on a row of CAPACITY cells, one result per request.
// ----------------------------------------------------------------------------
// Each request passes through the controller states accept, compare,
// update, result. The compare state registers per-cell flags against the key;
// the update state shifts the row one cell right (insert) or left (delete)
// from the point the flags mark. Requests are taken one at a time, and the
// result state waits while an untaken response fills the output register. A
// new request is accepted while the previous response still waits there.
// Inserts go after all equal values; a delete removes the first equal entry.
// An insert into a full store leaves it unchanged with status full; a delete
// with no equal entry leaves it unchanged with status not found. The count
// field shows the entry count modulo 32; head_value is zero when empty.
// Slots are not cleared at reset: only slots below the count are ever used.
// ----------------------------------------------------------------------------
module sorted_value_store
#(
    parameter int CAPACITY = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  svs_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output svs_pkg::rsp_t rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_UPD  = 4'b0100,
        S_RES  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic                               op_reg;
    logic signed [svs_pkg::VALUE_W-1:0] key_reg;
    logic [CW-1:0]                      count_reg, count_next;
    logic [svs_pkg::STATUS_W-1:0]       status_reg, status_next;
    logic                               rsp_valid_reg, rsp_valid_next;
    svs_pkg::rsp_t                      rsp_reg;

    svs_pkg::cell_cmd_t                 cmd;
    logic signed [svs_pkg::VALUE_W-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]                cell_le;
    logic [CAPACITY-1:0]                cell_eq;
    logic                               full;
    logic                               found;
    logic                               load_rsp;

    assign full  = (count_reg == CW'(CAPACITY));
    // Any occupied equal slot means the first slot at or above the key matches
    assign found = |cell_eq;

    // ---------------- cell row ----------------
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                               left_le;
        logic signed [svs_pkg::VALUE_W-1:0] left_value;
        logic signed [svs_pkg::VALUE_W-1:0] right_value;

        if (i == 0)
        begin : g_first
            // Head cell: an insert below the head value, or into an empty row, lands here
            assign left_le    = 1'b1;
            assign left_value = cell_value[i];
        end
        else
        begin : g_mid
            assign left_le    = cell_le[i-1];
            assign left_value = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_value = cell_value[i];
        end
        else
        begin : g_inner
            assign right_value = cell_value[i+1];
        end

        svs_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .key         (key_reg),
            .occ         (CW'(i) < count_reg),
            .left_le     (left_le),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[i]),
            .le          (cell_le[i]),
            .eq          (cell_eq[i])
        );
    end

    // ---------------- controller ----------------
    assign req_ready = (state_reg == S_IDLE);
    // Response register frees up when empty or being taken
    assign load_rsp  = (state_reg == S_RES) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        cmd.cmp_en  = (state_reg == S_CMP);
        cmd.ins_en  = (state_reg == S_UPD) && (op_reg == svs_pkg::OP_INSERT) && !full;
        cmd.del_en  = (state_reg == S_UPD) && (op_reg == svs_pkg::OP_DELETE) && found;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (op_reg == svs_pkg::OP_INSERT)
                begin
                    if (full)
                        status_next = svs_pkg::ST_FULL;
                    else
                    begin
                        status_next = svs_pkg::ST_DONE;
                        count_next  = count_reg + CW'(1);
                    end
                end
                else
                begin
                    if (found)
                    begin
                        status_next = svs_pkg::ST_DONE;
                        count_next  = count_reg - CW'(1);
                    end
                    else
                        status_next = svs_pkg::ST_NOT_FOUND;
                end
                state_next = S_RES;
            end
            S_RES:
            begin
                if (load_rsp)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load_rsp)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        if (req_valid && req_ready)
        begin
            op_reg  <= req.operation;
            key_reg <= req.value;
        end
        if (load_rsp)
        begin
            rsp_reg.status     <= status_reg;
            rsp_reg.count      <= svs_pkg::COUNT_W'(count_reg);
            rsp_reg.head_valid <= (count_reg != '0);
            rsp_reg.head_value <= (count_reg != '0) ? cell_value[0] : '0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
